@@ src/b64c_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64 codec package
// shared types, character constants and alphabet mapping functions
// ----------------------------------------------------------------------------
package b64c_pkg;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   // one group of up to four results, element 0 leaves first
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      count;
      logic            last;
      logic            err;
   } b64c_group_type;

   typedef struct packed {
      logic           valid;
      b64c_group_type grp;
   } b64c_push_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] s);
      logic [7:0] s8;
      s8 = {2'b00, s};
      case (s) inside
         [6'd0:6'd25]:  sextet_char = 8'(CHAR_UP_A + s8);
         [6'd26:6'd51]: sextet_char = 8'(CHAR_LO_A + s8 - 8'd26);
         [6'd52:6'd61]: sextet_char = 8'(CHAR_ZERO + s8 - 8'd52);
         6'd62:         sextet_char = CHAR_PLUS;
         default:       sextet_char = CHAR_SLASH;
      endcase
   endfunction

   function automatic logic [5:0] char_sextet(input logic [7:0] c);
      case (c) inside
         [8'h41:8'h5A]: char_sextet = 6'(c - CHAR_UP_A);
         [8'h61:8'h7A]: char_sextet = 6'(c - CHAR_LO_A + 8'd26);
         [8'h30:8'h39]: char_sextet = 6'(c - CHAR_ZERO + 8'd52);
         CHAR_PLUS:     char_sextet = 6'd62;
         CHAR_SLASH:    char_sextet = 6'd63;
         default:       char_sextet = 6'd0;
      endcase
   endfunction

endpackage : b64c_pkg
`default_nettype wire

@@ src/b64c_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64 codec input channel
// byte or character transfer with valid/ready handshake
// ----------------------------------------------------------------------------
interface b64c_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_in;
   logic       is_last;

   modport source (output valid, output data_in, output is_last, input ready);
   modport sink   (input valid, input data_in, input is_last, output ready);
endinterface : b64c_req_if
`default_nettype wire

@@ src/b64c_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64 codec result channel
// result transfer with valid/ready handshake
// ----------------------------------------------------------------------------
interface b64c_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic       out_last;
   logic       length_error;

   modport source (output valid, output data_out, output out_last, output length_error,
                   input ready);
   modport sink   (input valid, input data_out, input out_last, input length_error,
                   output ready);
endinterface : b64c_rsp_if
`default_nettype wire

@@ src/b64c_csr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64 codec configuration channel
// write of the direction register with valid/ready handshake
// ----------------------------------------------------------------------------
interface b64c_csr_if;
   logic valid;
   logic ready;
   logic decode_mode;

   modport source (output valid, output decode_mode, input ready);
   modport sink   (input valid, input decode_mode, output ready);
endinterface : b64c_csr_if
`default_nettype wire

@@ src/b64c_group.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64 group collector
// gathers bytes or characters into a group and forms its results
// ----------------------------------------------------------------------------
module b64c_group (
   input  wire logic                  clock,
   input  wire logic                  reset,
   b64c_req_if.sink                   req_ch,
   b64c_csr_if.sink                   csr_ch,
   input  wire logic                  hold_free,
   output b64c_pkg::b64c_push_type    push
);
   import b64c_pkg::*;

   localparam logic [1:0] DEC_LAST_SLOT = 2'd3;
   localparam logic [1:0] DEC_PAD_SLOT  = 2'd2;
   localparam logic [2:0] ENC_FULL      = 3'd3;

   logic        mode_ff, mode_in;
   logic [23:0] bits_ff, bits_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        twp_ff, twp_in;

   logic        accept;
   logic        csr_write;
   logic [23:0] enc_new;
   logic [23:0] enc_aligned;
   logic [2:0]  enc_n;
   logic [3:0][7:0] enc_chars;
   logic [5:0]  dec_sextet;
   logic [23:0] dec_new;
   logic        dec_pad;
   logic        dec_twp;
   logic [2:0]  dec_count;

   assign req_ch.ready = hold_free;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && hold_free;
   assign csr_write    = csr_ch.valid;

   always_comb begin
      enc_new = {bits_ff[15:0], req_ch.data_in};
      enc_n   = {1'b0, cnt_ff} + 3'd1;
      case (enc_n)
         3'd1:    enc_aligned = {enc_new[7:0], 16'h0000};
         3'd2:    enc_aligned = {enc_new[15:0], 8'h00};
         default: enc_aligned = enc_new;
      endcase
      for (int k = 0; k < 4; k++) begin
         enc_chars[k] = (3'(k) > enc_n) ? PAD_CHAR
                                        : sextet_char(enc_aligned[23 - 6 * k -: 6]);
      end

      dec_sextet = char_sextet(req_ch.data_in);
      dec_new    = {bits_ff[17:0], dec_sextet};
      dec_pad    = (req_ch.data_in == PAD_CHAR);
      dec_twp    = (cnt_ff == DEC_PAD_SLOT) ? dec_pad : twp_ff;
      dec_count  = (req_ch.is_last && dec_pad) ? (dec_twp ? 3'd1 : 3'd2) : 3'd3;
   end

   always_comb begin
      mode_in = mode_ff;
      bits_in = bits_ff;
      cnt_in  = cnt_ff;
      twp_in  = twp_ff;
      push    = '0;

      if (accept) begin
         if (!mode_ff) begin
            if ((enc_n == ENC_FULL) || req_ch.is_last) begin
               push.valid     = 1'b1;
               push.grp.data  = enc_chars;
               push.grp.count = 3'd4;
               push.grp.last  = req_ch.is_last;
               bits_in        = '0;
               cnt_in         = '0;
               if (req_ch.is_last) begin
                  twp_in = 1'b0;
               end
            end else begin
               bits_in = enc_new;
               cnt_in  = enc_n[1:0];
            end
         end else begin
            if (cnt_ff != DEC_LAST_SLOT) begin
               if (req_ch.is_last) begin
                  // stream ended mid-group: single error result
                  push.valid     = 1'b1;
                  push.grp.count = 3'd1;
                  push.grp.last  = 1'b1;
                  push.grp.err   = 1'b1;
                  bits_in        = '0;
                  cnt_in         = '0;
                  twp_in         = 1'b0;
               end else begin
                  bits_in = dec_new;
                  cnt_in  = 2'(cnt_ff + 2'd1);
                  twp_in  = dec_twp;
               end
            end else begin
               push.valid     = 1'b1;
               push.grp.data  = {8'h00, dec_new[7:0], dec_new[15:8], dec_new[23:16]};
               push.grp.count = dec_count;
               push.grp.last  = req_ch.is_last;
               bits_in        = '0;
               cnt_in         = '0;
               twp_in         = 1'b0;
            end
         end
      end

      if (csr_write) begin
         mode_in = csr_ch.decode_mode;
         bits_in = '0;
         cnt_in  = '0;
         twp_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         bits_ff <= '0;
         cnt_ff  <= '0;
         twp_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         bits_ff <= bits_in;
         cnt_ff  <= cnt_in;
         twp_ff  <= twp_in;
      end
   end

endmodule : b64c_group
`default_nettype wire

@@ src/b64c_serializer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64 result serialiser
// holds one pending group and sends the active group one result per cycle while the sink is ready
// ----------------------------------------------------------------------------
module b64c_serializer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire b64c_pkg::b64c_push_type push,
   output logic                       hold_free,
   b64c_rsp_if.source                 rsp_ch
);
   import b64c_pkg::*;

   logic           hold_valid_ff, hold_valid_in;
   b64c_group_type hold_ff, hold_in;
   b64c_group_type ser_ff, ser_in;
   logic [2:0]     left_ff, left_in;

   logic fire;
   logic load;

   assign hold_free = !hold_valid_ff;
   assign fire      = rsp_ch.valid && rsp_ch.ready;
   assign load      = hold_valid_ff && ((left_ff == 3'd0) || ((left_ff == 3'd1) && fire));

   assign rsp_ch.valid        = (left_ff != 3'd0);
   assign rsp_ch.data_out     = ser_ff.data[0];
   assign rsp_ch.out_last     = ser_ff.last && (left_ff == 3'd1);
   assign rsp_ch.length_error = ser_ff.err;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      ser_in        = ser_ff;
      left_in       = left_ff;

      if (load) begin
         ser_in        = hold_ff;
         left_in       = hold_ff.count;
         hold_valid_in = 1'b0;
      end else if (fire) begin
         ser_in.data = {8'h00, ser_ff.data[3:1]};
         left_in     = left_ff - 3'd1;
      end

      if (push.valid) begin
         hold_in       = push.grp;
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         left_ff       <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         left_ff       <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      ser_ff  <= ser_in;
   end

endmodule : b64c_serializer
`default_nettype wire

@@ src/base64_stream_codec_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// the group that a transfer closes is registered in the pending-group slot and then moved
// to the send register, from which its first result is offered; results leave at one result
// per cycle while the sink is ready, and a group of three bytes gives four results
// input is held back only while the single pending-group slot is occupied
// reset: encode direction, group state cleared, no results pending
// ----------------------------------------------------------------------------
// base64 stream codec core
// streaming base64 encoder/decoder with a direction register
// ----------------------------------------------------------------------------
module base64_stream_codec_core (
   input  wire logic  clock,
   input  wire logic  reset,
   b64c_req_if.sink   req_ch,
   b64c_rsp_if.source rsp_ch,
   b64c_csr_if.sink   csr_ch
);
   import b64c_pkg::*;

   // completed group handed from the collector to the output side
   b64c_push_type push;
   // pending slot empty, so a new input transfer can be taken
   logic          hold_free;

   // collector: direction register, 24-bit group word, item count and pad note;
   // on the closing item it forms up to four results in one pass
   b64c_group u_group (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .hold_free (hold_free),
      .push      (push)
   );

   // output side: one pending group plus the group being sent, so input
   // keeps flowing while results wait for the sink, until the pending slot fills
   b64c_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .hold_free (hold_free),
      .rsp_ch    (rsp_ch)
   );

endmodule : base64_stream_codec_core
`default_nettype wire

@@ verif/tb_base64_stream_codec_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64 stream codec core testbench
// drives byte and character streams in both directions through the codec and
// compares every result transfer against a cycle-free prediction of the
// codec, with random idling on both channels and periods of back-pressure
// ----------------------------------------------------------------------------

import b64c_pkg::PAD_CHAR;

localparam string B64_ALPHABET =
   "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

localparam bit MODE_ENCODE = 1'b0;
localparam bit MODE_DECODE = 1'b1;

typedef struct packed {
   logic [7:0] data;
   logic       last;
   logic       err;
} coded_word_type;

// predicted codec state and the queue of results still owed by the block
class base64_tracker;
   bit             dir_decode;
   logic [23:0]    acc_bits;
   int             acc_fill;
   bit             pad_in_third;
   coded_word_type coded_queue[$];
   int unsigned    mismatches;

   function new();
      dir_decode = MODE_ENCODE;
      mismatches = 0;
      clear_group();
   endfunction

   function void clear_group();
      acc_bits     = '0;
      acc_fill     = 0;
      pad_in_third = 1'b0;
   endfunction

   // a direction write drops any half-collected group
   function void set_mode(bit m);
      dir_decode = m;
      clear_group();
   endfunction

   function logic [5:0] char_value(logic [7:0] c);
      if (c >= "A" && c <= "Z") return 6'(c - "A");
      if (c >= "a" && c <= "z") return 6'(c - "a" + 8'd26);
      if (c >= "0" && c <= "9") return 6'(c - "0" + 8'd52);
      if (c == "+") return 6'd62;
      if (c == "/") return 6'd63;
      return 6'd0;
   endfunction

   function void push_word(logic [7:0] d, logic l, logic e);
      coded_word_type w;
      w.data = d;
      w.last = l;
      w.err  = e;
      coded_queue.push_back(w);
   endfunction

   function void note_input(logic [7:0] d, logic l);
      logic [23:0] bits;
      logic [7:0]  c;
      int          fill;
      int          cnt;
      if (dir_decode == MODE_ENCODE) begin
         acc_bits = {acc_bits[15:0], d};
         fill = acc_fill + 1;
         if (fill < 3 && !l) begin
            acc_fill = fill;
            return;
         end
         // short group is zero-filled from the right
         bits = acc_bits << (8 * (3 - fill));
         for (int k = 0; k < 4; k++) begin
            c = B64_ALPHABET[bits[23 - 6 * k -: 6]];
            if (k > fill) c = PAD_CHAR;
            push_word(c, l && (k == 3), 1'b0);
         end
         clear_group();
         return;
      end
      acc_bits = {acc_bits[17:0], char_value(d)};
      if (acc_fill == 2) pad_in_third = (d == PAD_CHAR);
      fill = acc_fill + 1;
      if (fill < 4) begin
         if (l) begin
            // stream ended mid-group
            push_word(8'h00, 1'b1, 1'b1);
            clear_group();
         end else begin
            acc_fill = fill;
         end
         return;
      end
      cnt = 3;
      if (l && d == PAD_CHAR) cnt = pad_in_third ? 1 : 2;
      for (int k = 0; k < cnt; k++)
         push_word(acc_bits[23 - 8 * k -: 8], l && (k == cnt - 1), 1'b0);
      clear_group();
   endfunction

   function void check_result(logic [7:0] d, logic l, logic e);
      coded_word_type w;
      if (coded_queue.size() == 0) begin
         $display("%0t: unexpected result data_out %02h out_last %0b length_error %0b",
                  $time, d, l, e);
         mismatches++;
         return;
      end
      w = coded_queue.pop_front();
      if (w.data !== d) begin
         $display("%0t: data_out expected %02h actual %02h", $time, w.data, d);
         mismatches++;
      end
      if (w.last !== l) begin
         $display("%0t: out_last expected %0b actual %0b", $time, w.last, l);
         mismatches++;
      end
      if (w.err !== e) begin
         $display("%0t: length_error expected %0b actual %0b", $time, w.err, e);
         mismatches++;
      end
   endfunction

   function int unsigned pending();
      return coded_queue.size();
   endfunction
endclass

module tb_base64_stream_codec_core;

   logic clock = 1'b0;
   logic reset = 1'b1;

   b64c_req_if req_if ();
   b64c_rsp_if rsp_if ();
   b64c_csr_if csr_if ();

   base64_tracker tracker;

   int unsigned items_sent    = 0;
   bit          sender_calm   = 1'b0;
   int          rsp_hold_left = 0;   // long receiver hold-off, counted down by the receiver

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   base64_stream_codec_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one input transfer, then an optional idle gap
   task automatic send_item(input logic [7:0] d, input logic l);
      int gap;
      req_if.valid   <= 1'b1;
      req_if.data_in <= d;
      req_if.is_last <= l;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker.note_input(d, l);
      items_sent++;
      gap = (sender_calm || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s, input bit last_at_end);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], last_at_end && (i == s.len() - 1));
   endtask

   // sender stops offering until every predicted result has been seen
   task automatic pause_until_drained();
      req_if.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // direction write on an idle block; the extra cycles cover a group still in flight
   task automatic write_mode(input bit m);
      pause_until_drained();
      repeat (6) @(posedge clock);
      csr_if.valid       <= 1'b1;
      csr_if.decode_mode <= m;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      tracker.set_mode(m);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_encode_stream(input int len);
      for (int i = 0; i < len; i++)
         send_item(8'($urandom_range(0, 255)), i == len - 1);
   endtask

   // well-formed groups with optional padding, some noise, and now and then a
   // truncated final group
   task automatic send_decode_stream(input int groups, input bit broken);
      int         pads;
      int         tail;
      logic [7:0] c;
      pads = $urandom_range(0, 2);
      tail = broken ? $urandom_range(1, 3) : 4;
      for (int g = 0; g < groups; g++) begin
         for (int j = 0; j < 4; j++) begin
            if (g == groups - 1 && j >= tail) break;
            c = B64_ALPHABET[$urandom_range(0, 63)];
            if (!broken && g == groups - 1 && j >= 4 - pads) c = PAD_CHAR;
            if ($urandom_range(0, 99) < 8) c = 8'($urandom_range(0, 255));
            send_item(c, (g == groups - 1) && (j == tail - 1));
         end
      end
   endtask

   // result side: check each transfer, then choose ready for the next cycle
   initial begin
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left  = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            tracker.check_result(rsp_if.data_out, rsp_if.out_last, rsp_if.length_error);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else if ($urandom_range(0, 99) < 4) begin
               calm_left = $urandom_range(30, 80);
            end else if ($urandom_range(0, 99) < 25) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      bit          mode;
      int unsigned target;
      bit          pressure_done;
      bit          pause_done;
      tracker = new();
      pressure_done = 1'b0;
      pause_done    = 1'b0;
      req_if.valid       <= 1'b0;
      req_if.data_in     <= 8'h00;
      req_if.is_last     <= 1'b0;
      csr_if.valid       <= 1'b0;
      csr_if.decode_mode <= MODE_ENCODE;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: encode a full group, one-byte and two-byte tails, extreme bytes
      write_mode(MODE_ENCODE);
      send_text("Man", 1'b1);
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b0);
      send_item(8'hFE, 1'b1);
      // half-collected group dropped by the direction write
      send_item(8'h12, 1'b0);
      write_mode(MODE_DECODE);

      // directed decode: full group, double and single pad, pads and
      // out-of-alphabet characters mid-stream, then a short final group
      send_text("TWFu", 1'b0);
      send_text("AA==", 1'b1);
      send_text("//8=", 1'b1);
      send_item(8'hFF, 1'b0);
      send_text("=+/", 1'b0);
      send_item(8'h00, 1'b0);
      send_text("A", 1'b1);

      // random phases, alternating direction
      for (int phase = 0; phase < 6; phase++) begin
         mode = (phase % 2 == 1) ? MODE_DECODE : MODE_ENCODE;
         write_mode(mode);
         target = items_sent + 12;
         while (items_sent < target) begin
            sender_calm = ($urandom_range(0, 9) < 2);
            if (phase == 2 && !pressure_done) begin
               // receiver held off while the sender keeps offering bytes
               pressure_done = 1'b1;
               rsp_hold_left = 300;
               sender_calm   = 1'b1;
               send_encode_stream(12);
            end else if (mode == MODE_ENCODE) begin
               send_encode_stream(($urandom_range(0, 9) < 8) ? $urandom_range(1, 8)
                                                             : $urandom_range(9, 16));
            end else begin
               send_decode_stream($urandom_range(1, 3), $urandom_range(0, 99) < 15);
            end
            if (phase == 3 && !pause_done) begin
               pause_done = 1'b1;
               pause_until_drained();
            end
         end
      end
      sender_calm = 1'b0;

      pause_until_drained();
      repeat (20) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("** base64_stream_codec_core: PASSED **");
      end else begin
         $display("** base64_stream_codec_core: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("** base64_stream_codec_core: FAILED **");
      $finish;
   end

endmodule : tb_base64_stream_codec_core
